>>> design/fecu_pkg.sv
// Shared types, constants and address helpers for the fire effect cell engine.
// Used by fire_effect_cell_update_core; depends on nothing else.
package fecu_pkg;

	localparam int FRAME_WIDTH  = 640;
	localparam int FRAME_HEIGHT = 480;
	localparam int FRAME_CELLS  = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int ADDR_W       = $clog2(FRAME_CELLS);
	// Signed linear addresses also cover row and column offsets below zero.
	localparam int LIN_W        = ADDR_W + 3;

	localparam int PIX_W  = 8;
	localparam int SUM_W  = 11;
	localparam int CNT_W  = 4;
	localparam int STEP_W = 4;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_SPARKLE_FLOOR   = '0;
	localparam logic [PIX_W-1:0]     SPARKLE_FLOOR_RESET = 8'd16;

	localparam logic [1:0] FUNC_SEED   = 2'd0;
	localparam logic [1:0] FUNC_UPDATE = 2'd1;
	localparam logic [1:0] FUNC_READ   = 2'd2;

	typedef logic signed [LIN_W-1:0] lin_t;

	function automatic logic in_frame(input lin_t a);
		return (a >= lin_t'(0)) && (a < lin_t'(FRAME_CELLS));
	endfunction

	// Gather order: lower-left first, then the seven masked neighbours.
	function automatic lin_t nbr_offset(input logic [2:0] idx);
		lin_t off;
		case (idx)
			3'd0: off = lin_t'(FRAME_WIDTH - 1);
			3'd1: off = lin_t'(-1);
			3'd2: off = lin_t'(-FRAME_WIDTH - 1);
			3'd3: off = lin_t'(-FRAME_WIDTH);
			3'd4: off = lin_t'(-FRAME_WIDTH + 1);
			3'd5: off = lin_t'(1);
			3'd6: off = lin_t'(FRAME_WIDTH + 1);
			3'd7: off = lin_t'(FRAME_WIDTH);
			default: off = '0;
		endcase
		return off;
	endfunction

	// Spread order: the cell itself, then left, right and up.
	function automatic lin_t spread_offset(input logic [1:0] idx);
		lin_t off;
		case (idx)
			2'd0: off = '0;
			2'd1: off = lin_t'(-1);
			2'd2: off = lin_t'(1);
			2'd3: off = lin_t'(-FRAME_WIDTH);
			default: off = '0;
		endcase
		return off;
	endfunction

endpackage

>>> design/fire_effect_cell_update_core.sv
// Fire effect cell engine: frame store, sequencer and shared adder/divider.
// Depends on fecu_pkg.
//
// Usage:
// A command is taken at a clock edge where start is high and busy is low; the
// fields func, col, row, level, gather_mask, spread_mask, sparkle_on,
// sparkle_dx and sparkle_dy are sampled at that edge. Every command gives one
// result beat: done is high for exactly one cycle with pixel and sparkled
// valid. The receiver cannot stall, so that beat must be taken when shown.
// A seed, an ignored command or an update with its row out of range ends in
// S_DECODE and a read ends in S_READ. The frame memory has a single port, so
// an update goes through gathering neighbours, the bit-serial divider, spread
// writes and, with sparkle on, the sparkle read-modify-write. busy is low
// again in the done cycle, so the next command may start there.
// After reset the frame store is cleared one pixel per cycle, all FRAME_CELLS
// (307200) of them, with busy high. sparkle_floor resets to 16 and is written
// through the APB port at any time, also during the clearing pass.
module fire_effect_cell_update_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [fecu_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [fecu_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [fecu_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          func,
	input  logic [9:0]                          col,
	input  logic [8:0]                          row,
	input  logic [7:0]                          level,
	input  logic [6:0]                          gather_mask,
	input  logic [2:0]                          spread_mask,
	input  logic                                sparkle_on,
	input  logic [9:0]                          sparkle_dx,
	input  logic [8:0]                          sparkle_dy,
	output logic                                done,
	output logic [7:0]                          pixel,
	output logic                                sparkled
);
	import fecu_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_READ,
		S_GATHER,
		S_GATHER_END,
		S_DIV,
		S_SPREAD,
		S_SPK_RD,
		S_SPK_CHK
	} state_t;

	state_t state_q;

	logic [ADDR_W-1:0] clr_q;
	logic [STEP_W-1:0] step_q;
	logic [1:0]        func_q;
	logic [9:0]        col_q;
	logic [8:0]        row_q;
	logic [7:0]        level_q;
	logic [6:0]        gmask_q;
	logic [2:0]        smask_q;
	logic              spon_q;
	logic [9:0]        dx_q;
	logic [8:0]        dy_q;
	lin_t              base_q;
	lin_t              spk_q;
	logic [SUM_W-1:0]  acc_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              pend_q;
	logic [SUM_W-1:0]  div_q;
	logic [CNT_W-1:0]  rem_q;
	logic              done_q;
	logic [PIX_W-1:0]  pixel_q;
	logic              sparkled_q;
	logic [PIX_W-1:0]  floor_q;

	logic [PIX_W-1:0]  frame_mem [FRAME_CELLS];
	logic [PIX_W-1:0]  rd_q;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_addr;
	logic [PIX_W-1:0]  mem_wdata;

	lin_t              mul_a;
	lin_t              mul_c;
	lin_t              prod;
	lin_t              nbr_addr;
	lin_t              spr_addr;
	logic [7:0]        gsel_vec;
	logic [3:0]        ssel_vec;
	logic              nbr_sel;
	logic              nbr_ok;
	logic              spr_en;
	logic [SUM_W-1:0]  acc_add;
	logic [CNT_W:0]    rem_sh;
	logic              q_bit;
	logic [CNT_W-1:0]  rem_n;
	logic              spk_hit;
	logic              row_ok;
	logic              cfg_wr;
	logic              res_last;

	assign pready   = 1'b1;
	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign pixel    = pixel_q;
	assign sparkled = sparkled_q;

	// Configuration register.
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[APB_ADDR_W-1:2] == REG_SPARKLE_FLOOR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= SPARKLE_FLOOR_RESET;
		end else if (cfg_wr) begin
			floor_q <= pwdata[PIX_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[APB_ADDR_W-1:2] == REG_SPARKLE_FLOOR) begin
			prdata = APB_DATA_W'(floor_q);
		end
	end

	// Shared linear address multiplier: the cell base at accept time (on the bottom
	// row for a seed), the sparkle target in the cycle after.
	always_comb begin
		if (state_q == S_IDLE) begin
			mul_a = (func == FUNC_SEED) ? lin_t'(FRAME_HEIGHT - 1) : lin_t'(row);
			mul_c = lin_t'(col);
		end else begin
			mul_a = lin_t'(row_q) - lin_t'(dy_q);
			mul_c = lin_t'(col_q) - lin_t'(dx_q);
		end
		prod = mul_a * lin_t'(FRAME_WIDTH) + mul_c;
	end

	assign gsel_vec = {gmask_q, 1'b1};
	assign ssel_vec = {smask_q, 1'b1};
	assign nbr_addr = base_q + nbr_offset(step_q[2:0]);
	assign spr_addr = base_q + spread_offset(step_q[1:0]);
	assign nbr_sel  = gsel_vec[step_q[2:0]];
	assign nbr_ok   = nbr_sel && in_frame(nbr_addr);
	assign spr_en   = ssel_vec[step_q[1:0]] && in_frame(spr_addr);
	assign acc_add  = acc_q + (pend_q ? SUM_W'(rd_q) : SUM_W'(0));
	assign spk_hit  = in_frame(spk_q) && (rd_q >= floor_q);
	assign row_ok   = (lin_t'(row_q) >= lin_t'(2))
		&& (lin_t'(row_q) <= lin_t'(FRAME_HEIGHT - 2));

	// One restoring division step per cycle.
	always_comb begin
		rem_sh = {rem_q, div_q[SUM_W-1]};
		q_bit  = (rem_sh >= {1'b0, cnt_q});
		rem_n  = q_bit ? CNT_W'(rem_sh - {1'b0, cnt_q}) : rem_sh[CNT_W-1:0];
	end

	// High in the last cycle of a command, so the result beat follows it.
	always_comb begin
		res_last = 1'b0;
		case (state_q)
			S_DECODE: begin
				res_last = (func_q != FUNC_READ)
					&& !((func_q == FUNC_UPDATE) && row_ok);
			end
			S_READ: begin
				res_last = 1'b1;
			end
			S_SPREAD: begin
				res_last = (step_q == STEP_W'(3)) && !spon_q;
			end
			S_SPK_CHK: begin
				res_last = 1'b1;
			end
			default: begin
				res_last = 1'b0;
			end
		endcase
	end

	// Frame memory port control.
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = base_q[ADDR_W-1:0];
		mem_wdata = div_q[PIX_W-1:0];
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = '0;
			end
			S_DECODE: begin
				mem_we    = (func_q == FUNC_SEED) && in_frame(base_q);
				mem_wdata = level_q;
			end
			S_GATHER: begin
				mem_addr = nbr_addr[ADDR_W-1:0];
			end
			S_SPREAD: begin
				mem_we   = spr_en;
				mem_addr = spr_addr[ADDR_W-1:0];
			end
			S_SPK_RD: begin
				mem_addr = spk_q[ADDR_W-1:0];
			end
			S_SPK_CHK: begin
				mem_we    = spk_hit;
				mem_addr  = spk_q[ADDR_W-1:0];
				mem_wdata = level_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			frame_mem[mem_addr] <= mem_wdata;
		end
		rd_q <= frame_mem[mem_addr];
	end

	// Sequencer and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			step_q     <= '0;
			done_q     <= 1'b0;
			sparkled_q <= 1'b0;
			pixel_q    <= '0;
			pend_q     <= 1'b0;
		end else begin
			done_q <= res_last;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(FRAME_CELLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						func_q  <= func;
						col_q   <= col;
						row_q   <= row;
						level_q <= level;
						gmask_q <= gather_mask;
						smask_q <= spread_mask;
						spon_q  <= sparkle_on;
						dx_q    <= sparkle_dx;
						dy_q    <= sparkle_dy;
						base_q  <= prod;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					spk_q  <= prod;
					step_q <= '0;
					acc_q  <= '0;
					cnt_q  <= '0;
					pend_q <= 1'b0;
					case (func_q)
						FUNC_SEED: begin
							pixel_q    <= level_q;
							sparkled_q <= 1'b0;
							state_q    <= S_IDLE;
						end
						FUNC_READ: begin
							state_q <= S_READ;
						end
						FUNC_UPDATE: begin
							if (row_ok) begin
								state_q <= S_GATHER;
							end else begin
								pixel_q    <= '0;
								sparkled_q <= 1'b0;
								state_q    <= S_IDLE;
							end
						end
						default: begin
							pixel_q    <= '0;
							sparkled_q <= 1'b0;
							state_q    <= S_IDLE;
						end
					endcase
				end
				S_READ: begin
					pixel_q    <= in_frame(base_q) ? rd_q : '0;
					sparkled_q <= 1'b0;
					state_q    <= S_IDLE;
				end
				S_GATHER: begin
					// Read data is registered, so each beat adds
					// the neighbour fetched in the cycle before.
					acc_q  <= acc_add;
					pend_q <= nbr_ok;
					if (nbr_sel) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(7)) begin
						state_q <= S_GATHER_END;
					end
				end
				S_GATHER_END: begin
					div_q   <= acc_add;
					rem_q   <= '0;
					step_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					div_q <= {div_q[SUM_W-2:0], q_bit};
					rem_q <= rem_n;
					if (step_q == STEP_W'(SUM_W - 1)) begin
						step_q  <= '0;
						state_q <= S_SPREAD;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				S_SPREAD: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(3)) begin
						if (spon_q) begin
							state_q <= S_SPK_RD;
						end else begin
							pixel_q    <= div_q[PIX_W-1:0];
							sparkled_q <= 1'b0;
							state_q    <= S_IDLE;
						end
					end
				end
				S_SPK_RD: begin
					state_q <= S_SPK_CHK;
				end
				S_SPK_CHK: begin
					pixel_q    <= div_q[PIX_W-1:0];
					sparkled_q <= spk_hit;
					state_q    <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
